[rtl/sfir_pkg.sv]
// Shared types and constants of the symmetric FIR line filter.
package sfir_pkg;

    localparam int SAMPLE_W       = 8;
    localparam int OUT_W          = 8;
    localparam int COEF_W         = 16;
    localparam int PROD_W         = SAMPLE_W + COEF_W;
    localparam int NUM_TAPS       = 16;
    localparam int TAP_IDX_W      = 4;
    localparam int TAPS_PER_GROUP = 4;
    localparam int NUM_GROUPS     = 4;
    localparam int GROUP_W        = 64;
    localparam int RADIUS_W       = 5;
    localparam int CFG_IDX_W      = 3;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(2);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_D = 3'd4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_PASS
    } t_state;

    // Strobes from the controller to the cell row and the result register.
    typedef struct packed {
        logic shift;
        logic capture;
    } t_ctrl;

endpackage

[rtl/sfir_cell.sv]
// One window cell: holds a sample and its tap, adds its product to the passing sum.
module sfir_cell
    import sfir_pkg::*;
#(
    parameter int ACC_W = 29
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [COEF_W-1:0]   i_coef,
    input  logic [ACC_W-1:0]    i_psum,
    output logic [SAMPLE_W-1:0] o_sample,
    output logic [ACC_W-1:0]    o_psum
);

    logic [SAMPLE_W-1:0] r_sample;
    logic [COEF_W-1:0]   r_coef;
    logic [ACC_W-1:0]    r_psum;
    logic [ACC_W-1:0]    n_psum;
    logic [PROD_W-1:0]   w_prod;

    always_comb begin
        w_prod = r_coef * r_sample;
        n_psum = i_psum + ACC_W'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    // Sum advances every cycle; it settles once sample and tap hold still.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_coef <= i_coef;
        end
        r_psum <= n_psum;
    end

    assign o_sample = r_sample;
    assign o_psum   = r_psum;

endmodule

[rtl/sfir_ctrl.sv]
// Sequencer: fill count, accumulation pass counter and result handshake.
module sfir_ctrl
    import sfir_pkg::*;
#(
    parameter int MAX_RADIUS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_line_start,
    input  logic [$clog2(2*MAX_RADIUS)-1:0]      i_len,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output t_ctrl                                o_ctrl
);

    localparam int WIN    = 2 * MAX_RADIUS - 1;
    localparam int FILL_W = $clog2(WIN + 1);

    t_state              r_state, n_state;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [FILL_W-1:0]   r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic [FILL_W-1:0]   w_fill_upd;
    logic                w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_ready  = (r_state == ST_IDLE);
        w_accept = i_valid && o_ready;
        if (i_line_start) begin
            w_fill_upd = FILL_W'(1);
        end else if (r_fill < FILL_W'(WIN)) begin
            w_fill_upd = r_fill + FILL_W'(1);
        end else begin
            w_fill_upd = r_fill;
        end

        n_state        = r_state;
        n_fill         = r_fill;
        n_cnt          = r_cnt;
        o_ctrl.shift   = 1'b0;
        o_ctrl.capture = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_ctrl.shift = 1'b1;
                    n_fill       = w_fill_upd;
                    if (w_fill_upd >= i_len) begin
                        n_state = ST_PASS;
                        n_cnt   = '0;
                    end
                end
            end
            ST_PASS: begin
                if (r_cnt != FILL_W'(WIN)) begin
                    n_cnt = r_cnt + FILL_W'(1);
                end else if (!r_out_valid || i_ready) begin
                    o_ctrl.capture = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (o_ctrl.capture) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_valid = r_out_valid;

endmodule

[rtl/symmetric_fir_line_filter_unit.sv]
// Top level of the symmetric FIR line filter: config registers, tap map and the cell row.
//
// Samples of an edge-padded line enter a row of 2*MAX_RADIUS-1 cells, the newest
// in cell 0. Each cell holds one window sample and its mirrored tap, and a running
// sum hops one cell per clock along the row, so the full weighted sum of the loaded
// window leaves the last cell. A sample that does not complete a window (fewer than
// 2R-1 samples since the last line start) yields no transaction on the output and
// the input is ready again the next clock. A sample that completes the window starts
// one pass along the cell row; the input stays not ready until the result register
// loads at the end of the pass and is ready again right after that edge, so a new
// sample is not taken while a pass is running. A finished result waits in its own
// register, so the next sample is taken while it is still pending; the pass only holds
// at its end if the previous result has still not been taken. The result is the
// weighted sum with its COEF_FRAC_BITS fraction bits dropped, saturated at 255 with
// o_clipped set.
// Config writes (o_cfg_ready is always high) belong in idle time: radius at index 0
// (clamped to 2..MAX_RADIUS), coefficient groups A..D at indexes 1..4, four 16-bit
// taps per group with the lowest tap in the low bits; other indexes are dropped.
module symmetric_fir_line_filter_unit
    import sfir_pkg::*;
#(
    parameter int MAX_RADIUS     = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_line_start,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [OUT_W-1:0]     o_filtered,
    output logic                 o_clipped,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GROUP_W-1:0]   i_cfg_data
);

    localparam int WIN    = 2 * MAX_RADIUS - 1;
    localparam int LEN_W  = $clog2(2 * MAX_RADIUS);
    localparam int CMP_W  = ($clog2(MAX_RADIUS + 1) > RADIUS_W) ?
                            $clog2(MAX_RADIUS + 1) : RADIUS_W;
    localparam int DIST_W = (LEN_W > TAP_IDX_W + 1) ? LEN_W : TAP_IDX_W + 1;
    localparam int SUM_W  = PROD_W + $clog2(WIN);
    localparam int ACC_W  = (SUM_W > COEF_FRAC_BITS + OUT_W + 1) ?
                            SUM_W : COEF_FRAC_BITS + OUT_W + 1;

    // Configuration registers.
    logic [RADIUS_W-1:0] r_radius;
    logic [GROUP_W-1:0]  r_coef_grp [NUM_GROUPS];

    // Result register.
    logic [OUT_W-1:0]    r_filtered;
    logic                r_clipped;

    t_ctrl               w_ctrl;
    logic [COEF_W-1:0]   w_tap    [NUM_TAPS];
    logic [CMP_W-1:0]    w_rad_ext;
    logic [CMP_W-1:0]    w_eff;
    logic [LEN_W-1:0]    w_len;
    logic [DIST_W-1:0]   w_ctr;
    logic [COEF_W-1:0]   w_coef   [WIN];
    logic [SAMPLE_W-1:0] w_sample [WIN];
    logic [ACC_W-1:0]    w_psum   [WIN];
    logic [ACC_W-1:0]    w_int;
    logic                w_clip;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_coef_grp[g] <= '0;
            end
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIUS: r_radius      <= i_cfg_data[RADIUS_W-1:0];
                CFG_COEF_A: r_coef_grp[0] <= i_cfg_data;
                CFG_COEF_B: r_coef_grp[1] <= i_cfg_data;
                CFG_COEF_C: r_coef_grp[2] <= i_cfg_data;
                CFG_COEF_D: r_coef_grp[3] <= i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Unpack the sixteen taps from the four groups.
    always_comb begin
        for (int t = 0; t < NUM_TAPS; t++) begin
            w_tap[t] = r_coef_grp[t / TAPS_PER_GROUP][(t % TAPS_PER_GROUP) * COEF_W +: COEF_W];
        end
    end

    // Clamp the radius, then derive the window length and its center cell.
    always_comb begin
        w_rad_ext = CMP_W'(r_radius);
        if (w_rad_ext < CMP_W'(2)) begin
            w_eff = CMP_W'(2);
        end else if (w_rad_ext > CMP_W'(MAX_RADIUS)) begin
            w_eff = CMP_W'(MAX_RADIUS);
        end else begin
            w_eff = w_rad_ext;
        end
        w_len = LEN_W'({w_eff, 1'b0} - (CMP_W + 1)'(1));
        w_ctr = DIST_W'(w_eff) - DIST_W'(1);
    end

    // Tap for each cell: distance from the center, zero outside the window
    // and beyond the last stored tap.
    for (genvar p = 0; p < WIN; p++) begin : g_tap_map
        logic [DIST_W-1:0] w_pos;
        logic [DIST_W-1:0] w_dist;
        always_comb begin
            w_pos  = DIST_W'(p);
            w_dist = (w_pos >= w_ctr) ? (w_pos - w_ctr) : (w_ctr - w_pos);
            if ((w_pos < DIST_W'(w_len)) && (w_dist < DIST_W'(NUM_TAPS))) begin
                w_coef[p] = w_tap[w_dist[TAP_IDX_W-1:0]];
            end else begin
                w_coef[p] = '0;
            end
        end
    end

    sfir_ctrl #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_line_start (i_line_start),
        .i_len        (w_len),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_ctrl       (w_ctrl)
    );

    // Cell row: samples shift toward the far end on each input transaction,
    // the running sum hops one cell per clock.
    for (genvar p = 0; p < WIN; p++) begin : g_cell
        logic [SAMPLE_W-1:0] w_in_sample;
        logic [ACC_W-1:0]    w_in_psum;
        if (p == 0) begin : g_head
            assign w_in_sample = i_sample;
            assign w_in_psum   = '0;
        end else begin : g_body
            assign w_in_sample = w_sample[p-1];
            assign w_in_psum   = w_psum[p-1];
        end

        sfir_cell #(
            .ACC_W (ACC_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (w_ctrl.shift),
            .i_sample (w_in_sample),
            .i_coef   (w_coef[p]),
            .i_psum   (w_in_psum),
            .o_sample (w_sample[p]),
            .o_psum   (w_psum[p])
        );
    end

    // Drop the fraction and saturate the integer part.
    always_comb begin
        w_int  = w_psum[WIN-1] >> COEF_FRAC_BITS;
        w_clip = |w_int[ACC_W-1:OUT_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.capture) begin
            r_filtered <= w_clip ? {OUT_W{1'b1}} : w_int[OUT_W-1:0];
            r_clipped  <= w_clip;
        end
    end

    assign o_filtered = r_filtered;
    assign o_clipped  = r_clipped;

endmodule

[dv/sfir_line_checker.sv]
// Scoreboard for the symmetric FIR line filter: predicts each output pixel and compares it.
module sfir_line_checker
    import sfir_pkg::*;
#(
    parameter int MAX_RADIUS     = 16,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [SAMPLE_W-1:0]  i_sample,
    input  logic                 i_line_start,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [OUT_W-1:0]     i_filtered,
    input  logic                 i_clipped,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [GROUP_W-1:0]   i_cfg_data,
    output int                   o_error_count,
    output int                   o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_MAX    = 2 * MAX_RADIUS - 1;
    localparam int OUT_MAX    = (1 << OUT_W) - 1;
    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [OUT_W-1:0] filtered;
        logic             clipped;
    } t_pixel;

    logic [RADIUS_W-1:0] radius_reg;
    logic [GROUP_W-1:0]  coef_group [NUM_GROUPS];
    logic [SAMPLE_W-1:0] line_window [WIN_MAX];
    int                  samples_since_start;
    t_pixel              expected_pixels [$];
    int                  fault_count = 0;

    task automatic report_fault(input string msg);
        if (fault_count < REPORT_CAP) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        fault_count++;
    endtask

    function automatic int active_radius();
        int r;
        r = radius_reg;
        if (r < 2) r = 2;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        return r;
    endfunction

    // Taps past the last coefficient group weigh nothing.
    function automatic logic [COEF_W-1:0] tap_weight(input int d);
        if (d >= NUM_TAPS) return '0;
        return coef_group[d / TAPS_PER_GROUP][(d % TAPS_PER_GROUP) * COEF_W +: COEF_W];
    endfunction

    // Shift one sample in and queue the pixel it completes, if any.
    function automatic void predict_pixel(input logic [SAMPLE_W-1:0] s, input logic start);
        int              r;
        int              len;
        int              d;
        longint unsigned acc;
        longint unsigned whole;
        t_pixel          px;
        r   = active_radius();
        len = 2 * r - 1;
        for (int p = WIN_MAX - 1; p > 0; p--) line_window[p] = line_window[p-1];
        line_window[0] = s;
        if (start) samples_since_start = 1;
        else if (samples_since_start < WIN_MAX) samples_since_start++;
        if (samples_since_start < len) return;
        acc = 0;
        for (int p = 0; p < len; p++) begin
            d = (p >= r - 1) ? p - (r - 1) : (r - 1) - p;
            acc += tap_weight(d) * line_window[p];
        end
        whole = acc >> COEF_FRAC_BITS;
        if (whole > OUT_MAX) begin
            px.filtered = '1;
            px.clipped  = 1'b1;
        end else begin
            px.filtered = whole[OUT_W-1:0];
            px.clipped  = 1'b0;
        end
        expected_pixels.push_back(px);
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            radius_reg = RADIUS_RESET;
            foreach (coef_group[g]) coef_group[g] = '0;
            foreach (line_window[p]) line_window[p] = '0;
            samples_since_start = 0;
            expected_pixels.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RADIUS: radius_reg    = i_cfg_data[RADIUS_W-1:0];
                    CFG_COEF_A: coef_group[0] = i_cfg_data;
                    CFG_COEF_B: coef_group[1] = i_cfg_data;
                    CFG_COEF_C: coef_group[2] = i_cfg_data;
                    CFG_COEF_D: coef_group[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report_fault($sformatf("pixel %0d clipped %0d with none expected",
                                           i_filtered, i_clipped));
                end else begin
                    want = expected_pixels.pop_front();
                    if (i_filtered !== want.filtered) begin
                        report_fault($sformatf("filtered got %0d expected %0d",
                                               i_filtered, want.filtered));
                    end
                    if (i_clipped !== want.clipped) begin
                        report_fault($sformatf("clipped got %0d expected %0d",
                                               i_clipped, want.clipped));
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_pixel(i_sample, i_line_start);
        end
        o_error_count   <= fault_count;
        o_pending_count <= expected_pixels.size();
    end

endmodule

[dv/symmetric_fir_line_filter_unit_tb.sv]
// Testbench top for the symmetric FIR line filter: stimulus, reset, timeout and verdict.
module symmetric_fir_line_filter_unit_tb
    import sfir_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_RADIUS     = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 5;
    // One full pass along the cell row plus some slack.
    localparam int DRAIN_CYCLES   = 2 * MAX_RADIUS + 8;
    localparam int CYCLE_LIMIT    = 500_000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 50;

    // Indexes past the register list; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {
        KERN_SPREAD,    // taps in use sum to at most one, so never clips
        KERN_RANDOM,    // every tap random
        KERN_SATURATE,  // every tap at full scale
        KERN_ZERO
    } t_kernel_kind;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_valid      = 1'b0;
    logic                 o_ready;
    logic [SAMPLE_W-1:0]  i_sample     = '0;
    logic                 i_line_start = 1'b0;
    logic                 o_valid;
    logic                 i_ready      = 1'b0;
    logic [OUT_W-1:0]     o_filtered;
    logic                 o_clipped;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [GROUP_W-1:0]   i_cfg_data   = '0;

    int          error_count;
    int          pending_count;
    int          idle_pct    = 0;   // chance per cycle that the sample source holds off
    int          stall_pct   = 0;   // chance per cycle that the pixel sink stalls
    int          window_len  = 3;   // 2R-1 for the kernel now loaded
    int unsigned cycle_count = 0;

    symmetric_fir_line_filter_unit #(
        .MAX_RADIUS     (MAX_RADIUS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .i_line_start (i_line_start),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_filtered   (o_filtered),
        .o_clipped    (o_clipped),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    sfir_line_checker #(
        .MAX_RADIUS     (MAX_RADIUS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_sample        (i_sample),
        .i_line_start    (i_line_start),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_filtered      (o_filtered),
        .i_clipped       (o_clipped),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Stall the pixel sink at random; with stall_pct at zero it takes every pixel.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Bound the run: a hung handshake or a lost pixel ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [GROUP_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offer one sample transaction, after a random hold-off, and wait until it is taken.
    // Valid stays high straight into the next sample when no hold-off is drawn.
    task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic start);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_sample     <= s;
        i_line_start <= start;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and hold until every predicted pixel has come out, then let the
    // cell row run empty. The first edge lets the checker count the last transaction.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Hold the config valid across back-to-back writes; the caller drops it.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [GROUP_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write radius and all four coefficient groups; only call with the block idle.
    task automatic write_kernel(input logic [RADIUS_W-1:0] rad,
                                input logic [GROUP_W-1:0] grp_a, input logic [GROUP_W-1:0] grp_b,
                                input logic [GROUP_W-1:0] grp_c, input logic [GROUP_W-1:0] grp_d);
        logic [GROUP_W-1:0] radius_word;
        int                 r;
        // Fill the bits above the radius field with junk; only the low field counts.
        radius_word                 = rand_word();
        radius_word[RADIUS_W-1:0]   = rad;
        r = rad;
        if (r < 2) r = 2;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        window_len = 2 * r - 1;
        write_register(CFG_RADIUS, radius_word);
        write_register(CFG_COEF_A, grp_a);
        write_register(CFG_COEF_B, grp_b);
        write_register(CFG_COEF_C, grp_c);
        write_register(CFG_COEF_D, grp_d);
        if ($urandom_range(0, 1) == 1) begin
            write_register(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                           rand_word());
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_kernel(input logic [RADIUS_W-1:0] rad, input t_kernel_kind kind);
        logic [GROUP_W-1:0] grp [NUM_GROUPS];
        int                 r;
        int                 budget;
        int                 tap;
        r = rad;
        if (r < 2) r = 2;
        if (r > MAX_RADIUS) r = MAX_RADIUS;
        // Keep the taps in use summing to at most 1.0 so every pixel lands in range.
        budget = (1 << COEF_FRAC_BITS) / (2 * r - 1);
        for (int g = 0; g < NUM_GROUPS; g++) begin
            case (kind)
                KERN_RANDOM:   grp[g] = rand_word();
                KERN_SATURATE: grp[g] = '1;
                KERN_ZERO:     grp[g] = '0;
                default: begin
                    for (int t = 0; t < TAPS_PER_GROUP; t++) begin
                        tap = g * TAPS_PER_GROUP + t;
                        // Taps outside the radius get junk; they must never be used.
                        grp[g][t * COEF_W +: COEF_W] = (tap < r) ?
                            COEF_W'($urandom_range(0, budget)) : COEF_W'($urandom);
                    end
                end
            endcase
        end
        write_kernel(rad, grp[0], grp[1], grp[2], grp[3]);
    endtask

    // Send mostly well-formed lines (start flag, then at least a full window) with
    // random content, mixed with lines cut short and bursts of random start flags.
    task automatic run_lines(input int n_items, input bit pause_midway);
        int                  sent;
        int                  len;
        int                  shape;
        int                  values;
        bit                  fresh;
        logic                start;
        logic [SAMPLE_W-1:0] s;
        sent  = 0;
        // Sometimes carry on the line from before the kernel change.
        fresh = ($urandom_range(0, 2) != 0);
        while (sent < n_items) begin
            shape  = $urandom_range(0, 9);
            values = $urandom_range(0, 3);
            if (shape < 8) len = window_len + $urandom_range(0, 24);
            else if (shape == 8) len = $urandom_range(1, window_len - 1);
            else len = $urandom_range(1, 8);
            for (int i = 0; i < len && sent < n_items; i++) begin
                if (shape == 9) start = ($urandom_range(0, 3) == 0);
                else start = (i == 0) && fresh;
                case (values)
                    2:       s = ($urandom_range(0, 1) == 1) ? '1 : '0;
                    3:       s = SAMPLE_W'($urandom_range(0, 15));
                    default: s = SAMPLE_W'($urandom_range(0, 255));
                endcase
                send_item(s, start);
                sent++;
                // Hold the source until the filter has emptied, then go on mid-line.
                if (pause_midway && sent == n_items / 2) wait_for_results();
            end
            fresh = 1'b1;
        end
    endtask

    initial begin
        logic [RADIUS_W-1:0] rad;
        t_kernel_kind        kind;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset kernel: radius 2 with all taps zero, so the one pixel is zero.
        send_item(8'd255, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        wait_for_results();

        // Full-scale center and neighbor taps: a bright window clips, a dark one
        // reads zero, and a line start in between restarts the fill.
        write_kernel(5'd2, {32'h0, 16'hFFFF, 16'hFFFF}, '0, '0, '0);
        send_item(8'd255, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd1, 1'b1);
        send_item(8'd1, 1'b0);
        send_item(8'd1, 1'b0);
        wait_for_results();

        // Radius below range acts as 2; taps past the radius hold junk.
        write_kernel(5'd0, {$urandom, 16'h4000, 16'h8000}, rand_word(), rand_word(),
                     rand_word());
        send_item(8'd128, 1'b1);
        send_item(8'd255, 1'b0);
        send_item(8'd1, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd0, 1'b0);
        send_item(8'd7, 1'b1);
        wait_for_results();

        // Random phases: rotate the idling pattern and walk the radius extremes first.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       rad = 5'd2;
                1:       rad = 5'd16;
                2:       rad = 5'd31;
                3:       rad = 5'd0;
                4:       rad = 5'd1;
                5:       rad = 5'd17;
                default: rad = RADIUS_W'($urandom_range(0, 31));
            endcase
            case (ph)
                1:       kind = KERN_SATURATE;
                3:       kind = KERN_ZERO;
                5:       kind = KERN_RANDOM;
                default: kind = ($urandom_range(0, 4) == 0) ? KERN_RANDOM : KERN_SPREAD;
            endcase
            load_kernel(rad, kind);
            case (ph % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 87;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 87;
                end
                default: begin
                    idle_pct  = 6;
                    stall_pct = 6;
                end
            endcase
            run_lines(PHASE_ITEMS, ph == 1 || ph == 6);
            wait_for_results();
        end

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
